@@ hw/rtl/pulse_width_bit_line_transceiver_macros.svh @@
// assertion macros shared by the rtl
`ifndef PULSE_WIDTH_BIT_LINE_TRANSCEIVER_MACROS_SVH
`define PULSE_WIDTH_BIT_LINE_TRANSCEIVER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold on every clock edge out of reset
`define PWBLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen
`define PWBLT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PWBLT_ASSERT(lbl, clk, rst_n, prop, msg)
`define PWBLT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

@@ hw/rtl/pwblt_pkg.sv @@
package pwblt_pkg;

    localparam int MAX_RX_BYTES = 64;

    localparam logic [7:0]  SAMPLE_DELAY_RST  = 8'd4;
    localparam logic [6:0]  RX_LENGTH_RST     = 7'd4;
    localparam logic [19:0] TIMEOUT_LIMIT_RST = 20'd120000;

    localparam int CHIPS_PER_BYTE = 32;

    // register word indexes, byte address is 4 * index
    typedef enum logic [1:0] {
        REG_SAMPLE_DELAY  = 2'd0,
        REG_RX_LENGTH     = 2'd1,
        REG_TIMEOUT_LIMIT = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ACT_SEND = 2'd0,
        ACT_TICK = 2'd1,
        ACT_ARM  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        RX_IDLE      = 3'd0,
        RX_WAIT_LOW  = 3'd1,
        RX_DELAY     = 3'd2,
        RX_WAIT_HIGH = 3'd3,
        RX_STOP_LOW  = 3'd4,
        RX_STOP_HIGH = 3'd5
    } t_rx_phase;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       line_in;
    } t_in_item;

    typedef struct packed {
        logic       line_out;
        logic       chip_valid;
        logic [7:0] rx_byte;
        logic       rx_byte_valid;
        logic       rx_done;
        logic       rx_timeout;
        logic       rx_busy;
        logic       last;
    } t_result;

endpackage

@@ hw/rtl/pwblt_in_if.sv @@
interface pwblt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       line_in;

    modport source (output valid, action, tx_byte, tx_last, line_in, input ready);
    modport sink (input valid, action, tx_byte, tx_last, line_in, output ready);
endinterface

@@ hw/rtl/pwblt_out_if.sv @@
interface pwblt_out_if;
    logic       valid;
    logic       ready;
    logic       line_out;
    logic       chip_valid;
    logic [7:0] rx_byte;
    logic       rx_byte_valid;
    logic       rx_done;
    logic       rx_timeout;
    logic       rx_busy;
    logic       last;

    modport source (output valid, line_out, chip_valid, rx_byte, rx_byte_valid, rx_done,
                    rx_timeout, rx_busy, last, input ready);
    modport sink (input valid, line_out, chip_valid, rx_byte, rx_byte_valid, rx_done,
                  rx_timeout, rx_busy, last, output ready);
endinterface

@@ hw/rtl/pulse_width_bit_line_transceiver.sv @@
// channel   dir  handshake      payload
// i_in      in   valid/ready    action, tx_byte, tx_last, line_in
// o_out     out  valid/ready    line_out, chip_valid, rx_byte, rx_byte_valid,
//                               rx_done, rx_timeout, rx_busy, last
// apb       in   psel/penable   paddr[3:0], pwdata, prdata, pready
//
// a tick or arm request gives one result, back to back unless o_out stalls
// a send request gives 32 chips (33 with the stop chip), one per cycle from the chip counter unless o_out stalls
// an accepted request passes through the work stage before it reaches the result register
// a two-entry input stage (work plus skid) keeps i_in.ready a register output
// reset is synchronous and clears valids, receiver state and registers to defaults
`include "pulse_width_bit_line_transceiver_macros.svh"

module pulse_width_bit_line_transceiver (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pwblt_in_if.sink          i_in,
    pwblt_out_if.source       o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // configuration
    logic [7:0]  r_sample_delay;
    logic [6:0]  r_rx_length;
    logic [19:0] r_timeout_limit;

    // request stages
    logic                  r_skid_valid;
    pwblt_pkg::t_in_item   r_skid;
    logic                  r_work_valid;
    pwblt_pkg::t_in_item   r_work;
    logic [5:0]            r_chip;

    // result register
    logic                  r_out_valid;
    pwblt_pkg::t_result    r_out;

    // receiver
    pwblt_pkg::t_rx_phase  r_phase, n_phase;
    logic [7:0]            r_shift, n_shift;
    logic [2:0]            r_bitc, n_bitc;
    logic [6:0]            r_bytec, n_bytec;
    logic [7:0]            r_scount, n_scount;
    logic [19:0]           r_tcount, n_tcount;

    pwblt_pkg::t_in_item   in_item;
    pwblt_pkg::t_result    n_out;
    logic                  out_free, out_load, work_adv, work_take, in_fire;
    logic                  is_send, is_tick, is_arm, send_end;
    logic [6:0]            eff_len;
    logic [7:0]            delay_eff, scount_inc;
    logic                  tx_bit;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (pwblt_pkg::t_reg_idx'(paddr[3:2]))
            pwblt_pkg::REG_SAMPLE_DELAY:  prdata = {24'd0, r_sample_delay};
            pwblt_pkg::REG_RX_LENGTH:     prdata = {25'd0, r_rx_length};
            pwblt_pkg::REG_TIMEOUT_LIMIT: prdata = {12'd0, r_timeout_limit};
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_delay  <= pwblt_pkg::SAMPLE_DELAY_RST;
            r_rx_length     <= pwblt_pkg::RX_LENGTH_RST;
            r_timeout_limit <= pwblt_pkg::TIMEOUT_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (pwblt_pkg::t_reg_idx'(paddr[3:2]))
                pwblt_pkg::REG_SAMPLE_DELAY:  r_sample_delay  <= pwdata[7:0];
                pwblt_pkg::REG_RX_LENGTH:     r_rx_length     <= pwdata[6:0];
                pwblt_pkg::REG_TIMEOUT_LIMIT: r_timeout_limit <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // request flow
    assign in_item.action  = i_in.action;
    assign in_item.tx_byte = i_in.tx_byte;
    assign in_item.tx_last = i_in.tx_last;
    assign in_item.line_in = i_in.line_in;

    assign i_in.ready = !r_skid_valid;
    assign in_fire    = i_in.valid && !r_skid_valid;

    assign is_send  = r_work.action == pwblt_pkg::ACT_SEND;
    assign is_tick  = r_work.action == pwblt_pkg::ACT_TICK;
    assign is_arm   = r_work.action == pwblt_pkg::ACT_ARM;
    assign send_end = r_chip == (r_work.tx_last ? 6'(pwblt_pkg::CHIPS_PER_BYTE)
                                                : 6'(pwblt_pkg::CHIPS_PER_BYTE - 1));

    assign out_free  = !r_out_valid || o_out.ready;
    assign out_load  = r_work_valid && (is_send || is_tick || is_arm) && out_free;
    // unused action code retires with no result
    assign work_adv  = r_work_valid && (!(is_send || is_tick || is_arm)
                                        || (out_load && (!is_send || send_end)));
    assign work_take = !r_work_valid || work_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_work_valid <= 1'b0;
            r_chip       <= 6'd0;
        end else begin
            if (work_take) begin
                if (r_skid_valid) begin
                    r_work_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_work_valid <= in_fire;
                end
            end else if (in_fire) begin
                r_skid_valid <= 1'b1;
            end
            if (work_adv) begin
                r_chip <= 6'd0;
            end else if (out_load && is_send) begin
                r_chip <= r_chip + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (work_take) begin
            r_work <= r_skid_valid ? r_skid : in_item;
        end
        if (in_fire && !(work_take && !r_skid_valid)) begin
            r_skid <= in_item;
        end
    end

    // result and receiver step
    assign eff_len    = (r_rx_length > 7'(pwblt_pkg::MAX_RX_BYTES))
                        ? 7'(pwblt_pkg::MAX_RX_BYTES) : r_rx_length;
    assign delay_eff  = (r_sample_delay == 8'd0) ? 8'd1 : r_sample_delay;
    assign scount_inc = r_scount + 8'd1;
    assign tx_bit     = r_work.tx_byte[3'd7 - r_chip[4:2]];

    always_comb begin
        n_phase  = r_phase;
        n_shift  = r_shift;
        n_bitc   = r_bitc;
        n_bytec  = r_bytec;
        n_scount = r_scount;
        n_tcount = r_tcount;

        n_out               = '0;
        n_out.line_out      = 1'b1;
        n_out.last          = 1'b1;

        if (is_send) begin
            n_out.chip_valid = 1'b1;
            n_out.last       = send_end;
            if (r_chip[5]) begin
                n_out.line_out = 1'b0;  // stop chip
            end else begin
                unique case (r_chip[1:0])
                    2'd0:    n_out.line_out = 1'b0;
                    2'd3:    n_out.line_out = 1'b1;
                    default: n_out.line_out = tx_bit;
                endcase
            end
        end else if (is_arm) begin
            n_shift  = 8'd0;
            n_bitc   = 3'd0;
            n_bytec  = 7'd0;
            n_scount = 8'd0;
            n_tcount = 20'd0;
            n_phase  = (eff_len == 7'd0) ? pwblt_pkg::RX_STOP_LOW : pwblt_pkg::RX_WAIT_LOW;
        end else if (is_tick && r_phase != pwblt_pkg::RX_IDLE) begin
            n_tcount = r_tcount + 20'd1;
            if (r_tcount >= r_timeout_limit) begin
                n_out.rx_timeout = 1'b1;
                n_phase          = pwblt_pkg::RX_IDLE;
            end else begin
                unique case (r_phase)
                    pwblt_pkg::RX_WAIT_LOW: begin
                        if (!r_work.line_in) begin
                            n_scount = 8'd0;
                            n_phase  = pwblt_pkg::RX_DELAY;
                        end
                    end
                    pwblt_pkg::RX_DELAY: begin
                        n_scount = scount_inc;
                        if (scount_inc >= delay_eff) begin
                            n_shift = {r_shift[6:0], r_work.line_in};
                            n_bitc  = r_bitc + 3'd1;
                            if (r_bitc == 3'd7) begin
                                n_out.rx_byte       = {r_shift[6:0], r_work.line_in};
                                n_out.rx_byte_valid = 1'b1;
                                n_shift             = 8'd0;
                                n_bytec             = r_bytec + 7'd1;
                            end
                            // a high read already meets the wait for high
                            if (r_work.line_in) begin
                                n_phase = (n_bytec >= eff_len) ? pwblt_pkg::RX_STOP_LOW
                                                               : pwblt_pkg::RX_WAIT_LOW;
                            end else begin
                                n_phase = pwblt_pkg::RX_WAIT_HIGH;
                            end
                        end
                    end
                    pwblt_pkg::RX_WAIT_HIGH: begin
                        if (r_work.line_in) begin
                            n_phase = (r_bytec >= eff_len) ? pwblt_pkg::RX_STOP_LOW
                                                           : pwblt_pkg::RX_WAIT_LOW;
                        end
                    end
                    pwblt_pkg::RX_STOP_LOW: begin
                        if (!r_work.line_in) begin
                            n_phase = pwblt_pkg::RX_STOP_HIGH;
                        end
                    end
                    pwblt_pkg::RX_STOP_HIGH: begin
                        if (r_work.line_in) begin
                            n_out.rx_done = 1'b1;
                            n_phase       = pwblt_pkg::RX_IDLE;
                        end
                    end
                    default: n_phase = pwblt_pkg::RX_IDLE;
                endcase
            end
        end

        n_out.rx_busy = is_send ? (r_phase != pwblt_pkg::RX_IDLE)
                                : (n_phase != pwblt_pkg::RX_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= pwblt_pkg::RX_IDLE;
            r_shift  <= 8'd0;
            r_bitc   <= 3'd0;
            r_bytec  <= 7'd0;
            r_scount <= 8'd0;
            r_tcount <= 20'd0;
        end else if (out_load && !is_send) begin
            r_phase  <= n_phase;
            r_shift  <= n_shift;
            r_bitc   <= n_bitc;
            r_bytec  <= n_bytec;
            r_scount <= n_scount;
            r_tcount <= n_tcount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.line_out      = r_out.line_out;
    assign o_out.chip_valid    = r_out.chip_valid;
    assign o_out.rx_byte       = r_out.rx_byte;
    assign o_out.rx_byte_valid = r_out.rx_byte_valid;
    assign o_out.rx_done       = r_out.rx_done;
    assign o_out.rx_timeout    = r_out.rx_timeout;
    assign o_out.rx_busy       = r_out.rx_busy;
    assign o_out.last          = r_out.last;

    `PWBLT_ASSERT(a_skid_behind_work, i_clk, i_rst_n,
                  r_skid_valid |-> r_work_valid, "skid full with empty work stage")
    `PWBLT_ASSERT(a_chip_only_in_send, i_clk, i_rst_n,
                  (r_chip != 6'd0) |-> (r_work_valid && is_send),
                  "chip counter running outside a send")
    `PWBLT_NEVER(a_chip_no_rx_flags, i_clk, i_rst_n,
                 r_out_valid && r_out.chip_valid
                 && (r_out.rx_byte_valid || r_out.rx_done || r_out.rx_timeout),
                 "receive flag on a transmit chip")
    `PWBLT_ASSERT(a_one_rx_event, i_clk, i_rst_n,
                  r_out_valid |-> ($countones({r_out.rx_byte_valid, r_out.rx_done,
                                               r_out.rx_timeout}) <= 1),
                  "more than one receive event in a result")
    `PWBLT_ASSERT(a_done_goes_idle, i_clk, i_rst_n,
                  (out_load && is_tick && n_out.rx_done) |=> (r_phase == pwblt_pkg::RX_IDLE),
                  "receiver not idle after done")

endmodule

@@ tb/pwblt_result_checker.sv @@
`timescale 1ns / 1ps

module pwblt_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pwblt_in_if         i_in,
    pwblt_out_if        i_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    // register copies
    logic [7:0]  delay_reg;
    logic [6:0]  length_reg;
    logic [19:0] limit_reg;

    // receiver state as the block should hold it
    pwblt_pkg::t_rx_phase rx_phase;
    logic [7:0]  rx_shift;
    int unsigned bits_in_byte;
    int unsigned bytes_got;
    logic [7:0]  since_edge;
    int unsigned ticks_armed;

    pwblt_pkg::t_result due_results[$];
    int          results_seen = 0;
    int          fails = 0;
    int          pending = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;

    function automatic int unsigned frame_bytes();
        return (length_reg > pwblt_pkg::MAX_RX_BYTES) ? pwblt_pkg::MAX_RX_BYTES : length_reg;
    endfunction

    function automatic pwblt_pkg::t_result pack_result(logic line, logic chip,
                                                       logic [7:0] rx_byte, logic byte_ok,
                                                       logic done, logic tmo, logic lst);
        pwblt_pkg::t_result r;
        r.line_out      = line;
        r.chip_valid    = chip;
        r.rx_byte       = rx_byte;
        r.rx_byte_valid = byte_ok;
        r.rx_done       = done;
        r.rx_timeout    = tmo;
        r.rx_busy       = (rx_phase != pwblt_pkg::RX_IDLE);
        r.last          = lst;
        return r;
    endfunction

    function automatic string fmt_result(pwblt_pkg::t_result r);
        return $sformatf("line=%b chip=%b byte=%h bv=%b done=%b tmo=%b busy=%b last=%b",
                         r.line_out, r.chip_valid, r.rx_byte, r.rx_byte_valid, r.rx_done,
                         r.rx_timeout, r.rx_busy, r.last);
    endfunction

    function automatic void report(string msg);
        fails++;
        if (fails <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    // bit high already seen: either the next bit or the stop bit
    function automatic void next_bit_or_stop();
        rx_phase = (bytes_got >= frame_bytes()) ? pwblt_pkg::RX_STOP_LOW
                                                : pwblt_pkg::RX_WAIT_LOW;
    endfunction

    function automatic void predict_line_results(pwblt_pkg::t_in_item req);
        int          b;
        int          c;
        int          n;
        int          total;
        logic        lv;
        logic [7:0]  got_byte;
        logic        byte_ok;
        logic        done;
        logic        tmo;
        int unsigned dly;
        n        = 0;
        total    = req.tx_last ? pwblt_pkg::CHIPS_PER_BYTE + 1 : pwblt_pkg::CHIPS_PER_BYTE;
        got_byte = 8'd0;
        byte_ok  = 1'b0;
        done     = 1'b0;
        tmo      = 1'b0;
        dly      = (delay_reg == 8'd0) ? 1 : delay_reg;
        case (req.action)
            pwblt_pkg::ACT_SEND: begin
                for (b = 7; b >= 0; b--) begin
                    for (c = 0; c < 4; c++) begin
                        lv = (c == 0) ? 1'b0 : (c == 3) ? 1'b1 : req.tx_byte[b];
                        n++;
                        due_results.push_back(pack_result(lv, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0,
                                                          n == total));
                    end
                end
                // stop chip, then the line is released
                if (req.tx_last) begin
                    due_results.push_back(pack_result(1'b0, 1'b1, 8'd0, 1'b0, 1'b0, 1'b0,
                                                      1'b1));
                end
            end
            pwblt_pkg::ACT_ARM: begin
                rx_shift     = 8'd0;
                bits_in_byte = 0;
                bytes_got    = 0;
                since_edge   = 8'd0;
                ticks_armed  = 0;
                rx_phase     = (frame_bytes() == 0) ? pwblt_pkg::RX_STOP_LOW
                                                    : pwblt_pkg::RX_WAIT_LOW;
                due_results.push_back(pack_result(1'b1, 1'b0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b1));
            end
            pwblt_pkg::ACT_TICK: begin
                if (rx_phase != pwblt_pkg::RX_IDLE) begin
                    ticks_armed++;
                    if (ticks_armed > limit_reg) begin
                        tmo      = 1'b1;
                        rx_phase = pwblt_pkg::RX_IDLE;
                    end else begin
                        case (rx_phase)
                            pwblt_pkg::RX_WAIT_LOW: begin
                                if (!req.line_in) begin
                                    since_edge = 8'd0;
                                    rx_phase   = pwblt_pkg::RX_DELAY;
                                end
                            end
                            pwblt_pkg::RX_DELAY: begin
                                since_edge = since_edge + 8'd1;
                                if (since_edge >= dly) begin
                                    rx_shift = {rx_shift[6:0], req.line_in};
                                    bits_in_byte++;
                                    if (bits_in_byte >= 8) begin
                                        bits_in_byte = 0;
                                        got_byte     = rx_shift;
                                        byte_ok      = 1'b1;
                                        rx_shift     = 8'd0;
                                        bytes_got++;
                                    end
                                    if (req.line_in) begin
                                        next_bit_or_stop();
                                    end else begin
                                        rx_phase = pwblt_pkg::RX_WAIT_HIGH;
                                    end
                                end
                            end
                            pwblt_pkg::RX_WAIT_HIGH: begin
                                if (req.line_in) begin
                                    next_bit_or_stop();
                                end
                            end
                            pwblt_pkg::RX_STOP_LOW: begin
                                if (!req.line_in) begin
                                    rx_phase = pwblt_pkg::RX_STOP_HIGH;
                                end
                            end
                            pwblt_pkg::RX_STOP_HIGH: begin
                                if (req.line_in) begin
                                    done     = 1'b1;
                                    rx_phase = pwblt_pkg::RX_IDLE;
                                end
                            end
                            default: begin
                                rx_phase = pwblt_pkg::RX_IDLE;
                            end
                        endcase
                    end
                end
                due_results.push_back(pack_result(1'b1, 1'b0, got_byte, byte_ok, done, tmo,
                                                  1'b1));
            end
            default: begin
                // unused action code is dropped without a result
            end
        endcase
    endfunction

    function automatic void check_result();
        pwblt_pkg::t_result got;
        pwblt_pkg::t_result want;
        string   diffs;
        got.line_out      = i_out.line_out;
        got.chip_valid    = i_out.chip_valid;
        got.rx_byte       = i_out.rx_byte;
        got.rx_byte_valid = i_out.rx_byte_valid;
        got.rx_done       = i_out.rx_done;
        got.rx_timeout    = i_out.rx_timeout;
        got.rx_busy       = i_out.rx_busy;
        got.last          = i_out.last;
        results_seen++;
        if (due_results.size() == 0) begin
            report($sformatf("result %0d with nothing expected: %s", results_seen,
                             fmt_result(got)));
        end else begin
            want  = due_results.pop_front();
            diffs = "";
            if (got.line_out !== want.line_out)           diffs = {diffs, " line_out"};
            if (got.chip_valid !== want.chip_valid)       diffs = {diffs, " chip_valid"};
            if (got.rx_byte !== want.rx_byte)             diffs = {diffs, " rx_byte"};
            if (got.rx_byte_valid !== want.rx_byte_valid) diffs = {diffs, " rx_byte_valid"};
            if (got.rx_done !== want.rx_done)             diffs = {diffs, " rx_done"};
            if (got.rx_timeout !== want.rx_timeout)       diffs = {diffs, " rx_timeout"};
            if (got.rx_busy !== want.rx_busy)             diffs = {diffs, " rx_busy"};
            if (got.last !== want.last)                   diffs = {diffs, " last"};
            if (diffs != "") begin
                report($sformatf("result %0d differs in%s\n  expected %s\n  actual   %s",
                                 results_seen, diffs, fmt_result(want), fmt_result(got)));
            end
        end
    endfunction

    always @(posedge i_clk) begin
        pwblt_pkg::t_in_item req;
        logic [31:0]         reg_word;
        if (!i_rst_n) begin
            delay_reg    = pwblt_pkg::SAMPLE_DELAY_RST;
            length_reg   = pwblt_pkg::RX_LENGTH_RST;
            limit_reg    = pwblt_pkg::TIMEOUT_LIMIT_RST;
            rx_phase     = pwblt_pkg::RX_IDLE;
            rx_shift     = 8'd0;
            bits_in_byte = 0;
            bytes_got    = 0;
            since_edge   = 8'd0;
            ticks_armed  = 0;
            due_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                check_result();
            end
            if (i_in.valid && i_in.ready) begin
                req.action  = i_in.action;
                req.tx_byte = i_in.tx_byte;
                req.tx_last = i_in.tx_last;
                req.line_in = i_in.line_in;
                predict_line_results(req);
            end
            if (i_psel && i_penable && i_pready) begin
                case (pwblt_pkg::t_reg_idx'(i_paddr[3:2]))
                    pwblt_pkg::REG_SAMPLE_DELAY:  reg_word = {24'd0, delay_reg};
                    pwblt_pkg::REG_RX_LENGTH:     reg_word = {25'd0, length_reg};
                    pwblt_pkg::REG_TIMEOUT_LIMIT: reg_word = {12'd0, limit_reg};
                    default:                      reg_word = 32'd0;
                endcase
                if (i_pwrite) begin
                    case (pwblt_pkg::t_reg_idx'(i_paddr[3:2]))
                        pwblt_pkg::REG_SAMPLE_DELAY:  delay_reg  = i_pwdata[7:0];
                        pwblt_pkg::REG_RX_LENGTH:     length_reg = i_pwdata[6:0];
                        pwblt_pkg::REG_TIMEOUT_LIMIT: limit_reg  = i_pwdata[19:0];
                        default: ;
                    endcase
                end else if (i_prdata !== reg_word) begin
                    report($sformatf("register read at %h: expected %h actual %h",
                                     i_paddr, reg_word, i_prdata));
                end
            end
        end
        pending = due_results.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'd0;
    logic [31:0] pwdata  = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_results;
    int send_idle_pct = 14;
    int recv_idle_pct = 88;
    int hold_requests = 0;
    int accepted      = 0;
    int cycles        = 0;

    // what the sender believes is configured, to shape frames
    logic [7:0] cur_delay  = pwblt_pkg::SAMPLE_DELAY_RST;
    logic [6:0] cur_length = pwblt_pkg::RX_LENGTH_RST;

    pwblt_in_if  req_ch ();
    pwblt_out_if res_ch ();

    pulse_width_bit_line_transceiver i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pwblt_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (req_ch),
        .i_out        (res_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** pulse_width_bit_line_transceiver: FAILED **");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready = 1'b0;
            end else begin
                res_ch.ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer(logic [1:0] act, logic [7:0] data, logic lst, logic line);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.action  = act;
        req_ch.tx_byte = data;
        req_ch.tx_last = lst;
        req_ch.line_in = line;
        do @(posedge i_clk); while (!req_ch.ready);
        if (act != ACT_UNUSED) begin
            accepted++;
        end
    endtask

    task automatic tick(logic line);
        offer(pwblt_pkg::ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), line);
    endtask

    task automatic send(logic [7:0] data, logic lst);
        offer(pwblt_pkg::ACT_SEND, data, lst, 1'($urandom_range(0, 1)));
    endtask

    task automatic arm();
        offer(pwblt_pkg::ACT_ARM, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        // a dropped request leaves nothing to wait for, so allow it to clear
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(pwblt_pkg::t_reg_idx idx, logic wr, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic read_registers();
        apb_access(pwblt_pkg::REG_SAMPLE_DELAY, 1'b0, 32'd0);
        apb_access(pwblt_pkg::REG_RX_LENGTH, 1'b0, 32'd0);
        apb_access(pwblt_pkg::REG_TIMEOUT_LIMIT, 1'b0, 32'd0);
    endtask

    task automatic set_registers(logic [7:0] dly, logic [6:0] len, logic [19:0] limit);
        wait_drained();
        apb_access(pwblt_pkg::REG_SAMPLE_DELAY, 1'b1, {24'd0, dly});
        apb_access(pwblt_pkg::REG_RX_LENGTH, 1'b1, {25'd0, len});
        apb_access(pwblt_pkg::REG_TIMEOUT_LIMIT, 1'b1, {12'd0, limit});
        cur_delay  = dly;
        cur_length = len;
        read_registers();
    endtask

    function automatic int frame_len();
        return (cur_length > pwblt_pkg::MAX_RX_BYTES) ? pwblt_pkg::MAX_RX_BYTES : cur_length;
    endfunction

    // falling edge, filler samples, the sampled level, then release if it was low
    task automatic rx_bit(logic b);
        int d;
        d = (cur_delay == 8'd0) ? 1 : cur_delay;
        repeat ($urandom_range(0, 1)) tick(1'b1);
        tick(1'b0);
        repeat (d - 1) tick(1'($urandom_range(0, 1)));
        tick(b);
        if (!b) begin
            repeat ($urandom_range(0, 1)) tick(1'b0);
            tick(1'b1);
        end
    endtask

    // cut >= 0 abandons the frame at that bit
    task automatic rx_frame(int nbytes, int cut);
        int         i;
        int         b;
        logic [7:0] value;
        arm();
        for (i = 0; i < nbytes; i++) begin
            value = 8'($urandom_range(0, 255));
            for (b = 7; b >= 0; b--) begin
                if (i * 8 + (7 - b) == cut) begin
                    return;
                end
                rx_bit(value[b]);
            end
        end
        repeat ($urandom_range(0, 1)) tick(1'b1);
        tick(1'b0);
        repeat ($urandom_range(0, 1)) tick(1'b0);
        tick(1'b1);
    endtask

    task automatic random_phase(int n);
        int start;
        int r;
        start = accepted;
        while (accepted - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                rx_frame(frame_len(), -1);
            end else if (r < 65) begin
                rx_frame(frame_len(), $urandom_range(0, frame_len() * 8));
            end else if (r < 85) begin
                send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    offer(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
        end
    endtask

    initial begin
        req_ch.valid   = 1'b0;
        req_ch.action  = pwblt_pkg::ACT_TICK;
        req_ch.tx_byte = 8'd0;
        req_ch.tx_last = 1'b0;
        req_ch.line_in = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        read_registers();
        send(8'h00, 1'b0);
        send(8'hFF, 1'b1);
        send(8'hA5, 1'b1);
        offer(ACT_UNUSED, 8'h5A, 1'b1, 1'b0);
        tick(1'b0);
        tick(1'b1);
        arm();
        // bit read high, next edge awaited straight away
        tick(1'b0);
        repeat (3) tick(1'b1);
        tick(1'b1);
        // bit read low, then the wait for high
        tick(1'b0);
        repeat (3) tick(1'b1);
        tick(1'b0);
        tick(1'b1);
        // re-arm mid reception, then send while busy
        arm();
        send(8'h3C, 1'b0);
        tick(1'b0);
        tick(1'b1);

        // zero delay, zero length, zero limit: first tick times out
        set_registers(8'd0, 7'd0, 20'd0);
        arm();
        tick(1'b1);
        tick(1'b0);
        // zero length goes straight to the stop bit
        set_registers(8'd0, 7'd0, 20'd2);
        arm();
        tick(1'b0);
        tick(1'b1);

        set_registers(8'd0, 7'd1, 20'hFFFFF);
        random_phase(10);

        send_idle_pct = 88;
        recv_idle_pct = 14;
        set_registers(8'd2, 7'd1, 20'd80);
        random_phase(10);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_registers(8'd1, 7'd2, pwblt_pkg::TIMEOUT_LIMIT_RST);
        random_phase(10);

        // back-pressure: result side holds off while sends keep coming
        wait_drained();
        hold_requests++;
        repeat (10) send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        wait_drained();

        // longest sample delay: the bit is still pending when the limit runs out
        set_registers(8'd255, 7'd1, 20'd12);
        arm();
        tick(1'b0);
        repeat (12) tick(1'b1);
        // length above the maximum, frame cut short
        set_registers(8'd1, 7'd127, pwblt_pkg::TIMEOUT_LIMIT_RST);
        rx_frame(frame_len(), 10);

        wait_drained();
        if (fail_count == 0) begin
            $display("** pulse_width_bit_line_transceiver: PASSED **");
        end else begin
            $display("** pulse_width_bit_line_transceiver: FAILED **");
        end
        $finish;
    end

endmodule
